>>> rtl/fba_pkg.sv
// fba_pkg: constants, opcodes and the run-count helper for the fragment allocator
// no dependencies
`default_nettype none
package fba_pkg;
    localparam int GROUP_FRAGS = 4096;
    localparam int BLK_FRAGS   = 8;
    localparam int NUM_BLOCKS  = GROUP_FRAGS / BLK_FRAGS;
    localparam int BLK_W       = $clog2(NUM_BLOCKS);

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_EXTEND = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_INIT   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    typedef logic [2:0] t_cnt3;
    typedef t_cnt3 t_runs [1:7];

    // free runs of each length 1..7 inside one block map byte
    function automatic t_runs count_runs(input logic [7:0] m);
        t_runs c;
        logic [3:0] run;
        for (int k = 1; k < 8; k++) c[k] = '0;
        run = '0;
        for (int i = 0; i < 9; i++) begin
            if (i < 8 && m[i]) begin
                run = run + 4'd1;
            end else begin
                if (run != 4'd0 && run != 4'd8) c[run[2:0]] = c[run[2:0]] + 3'd1;
                run = '0;
            end
        end
        return c;
    endfunction
endpackage
`default_nettype wire

>>> rtl/fragment_block_allocator.sv
// fragment_block_allocator: free-fragment bitmap manager for one cylinder group
// depends on fba_pkg and fba_ram
// result path: extend/free go through read and modify, early rejects skip modify, allocate scans block by block
// init: a clearing pass rewrites every map byte, then the result beat follows
// throughput: one item at a time, next input beat the cycle after the result beat
// reset: synchronous active low; runs the same clearing pass, no item taken meanwhile
`default_nettype none
module fragment_block_allocator
    import fba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [11:0] i_frag_index,
    input  wire logic [3:0]  i_old_count,
    input  wire logic [3:0]  i_run_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [11:0]      o_alloc_index,
    output logic [9:0]       o_free_blocks,
    output logic [12:0]      o_part_frags
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;  // address issued, wait for data
    localparam logic [2:0] S_MOD   = 3'd3;  // data valid, modify and write back
    localparam logic [2:0] S_SCAN  = 3'd4;  // allocate scan, one block per cycle
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [BLK_W-1:0] r_addr, n_addr;
    logic [11:0]      r_data_start;
    logic [1:0]       r_op;
    logic [11:0]      r_idx;
    logic [3:0]       r_oldc, r_len;
    logic [9:0]       r_blocks, n_blocks;
    logic [12:0]      r_frags, n_frags;
    logic [12:0]      r_runs [1:7];
    logic [12:0]      n_runs [1:7];
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_status, n_status;
    logic [11:0]      r_where, n_where;

    logic             ram_we;
    logic [BLK_W-1:0] ram_addr;
    logic [7:0]       ram_wdata, ram_rdata;

    fba_ram #(.WIDTH(8), .DEPTH(NUM_BLOCKS)) u_map (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    // first block at or after data_start, rounded up to a block boundary
    logic [12:0] start_blk13;
    assign start_blk13 = ({1'b0, r_data_start} + 13'd7) >> 3;

    logic [2:0] off;
    logic [3:0] end4, first4;
    logic [7:0] run_mask, new_byte;
    t_runs      cb, ca;
    // an allocation always starts at the block base
    assign off    = (r_op == OP_ALLOC) ? 3'd0 : r_idx[2:0];
    assign first4 = {1'b0, off} + ((r_op == OP_EXTEND) ? r_oldc : 4'd0);
    assign end4   = {1'b0, off} + r_len;

    always_comb begin
        run_mask = '0;
        for (int i = 0; i < 8; i++)
            if (4'(i) >= first4 && 4'(i) < end4) run_mask[i] = 1'b1;
    end

    assign new_byte = (r_op == OP_FREE) ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
    assign cb = count_runs(ram_rdata);
    assign ca = count_runs(new_byte);

    // early validity checks on the captured request
    logic bad_len, ext_past;
    always_comb begin
        bad_len  = 1'b0;
        ext_past = 1'b0;
        case (r_op)
            OP_ALLOC:  bad_len = (r_len == 4'd0) || (r_len > 4'd8);
            OP_EXTEND: begin
                bad_len  = (r_len <= r_oldc) || (r_len > 4'd8);
                ext_past = end4 > 4'd8;
            end
            OP_FREE:   bad_len = (r_len == 4'd0) || (r_len > 4'd8) || (end4 > 4'd8);
            default:   bad_len = 1'b0;
        endcase
    end

    logic [12:0] sum_frags;
    assign sum_frags = r_frags + {9'd0, r_len};

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_blocks = r_blocks;
        n_frags  = r_frags;
        n_runs   = r_runs;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_where  = r_where;
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = 8'hFF;
        o_ready   = 1'b0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                // write all-free into every map byte
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == BLK_W'(NUM_BLOCKS - 1)) begin
                    n_addr  = '0;
                    n_state = (r_op == OP_INIT) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = !r_ovalid;
                n_addr  = '0;
            end
            S_READ: begin
                n_state = S_MOD;
                if (r_op == OP_INIT) begin
                    n_blocks = 10'(NUM_BLOCKS);
                    n_frags  = '0;
                    for (int k = 1; k < 8; k++) n_runs[k] = '0;
                    n_status = ST_OK;
                    n_addr   = '0;
                    n_state  = S_CLEAR;
                end else if (bad_len) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else if (r_op == OP_EXTEND && ext_past) begin
                    n_status = ST_NOSPACE;
                    n_state  = S_DONE;
                end else if (r_op == OP_ALLOC) begin
                    if (r_blocks == 10'd0 || start_blk13 >= 13'(NUM_BLOCKS)) begin
                        n_status = ST_NOSPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_addr   = start_blk13[BLK_W-1:0];
                        ram_addr = start_blk13[BLK_W-1:0];
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // ram_rdata holds byte at r_addr, issued last cycle
                if (ram_rdata == 8'hFF) begin
                    ram_we    = 1'b1;
                    ram_wdata = ~run_mask;
                    n_blocks  = (r_blocks == 10'd0) ? 10'd0 : r_blocks - 10'd1;
                    n_frags   = r_frags + 13'(8 - r_len);
                    if (r_len != 4'd8)
                        n_runs[3'(8 - r_len)] = r_runs[3'(8 - r_len)] + 13'd1;
                    n_status  = ST_OK;
                    n_where   = {r_addr, 3'b000};
                    n_state   = S_DONE;
                end else if (r_addr == BLK_W'(NUM_BLOCKS - 1)) begin
                    n_status = ST_NOSPACE;
                    n_state  = S_DONE;
                end else begin
                    n_addr   = r_addr + 1'b1;
                    ram_addr = r_addr + 1'b1;
                end
            end
            S_MOD: begin
                n_state = S_DONE;
                if (r_op == OP_EXTEND && ((ram_rdata & run_mask) != run_mask)) begin
                    n_status = ST_NOSPACE;
                end else if (r_op == OP_FREE && ((ram_rdata & run_mask) != 8'd0)) begin
                    n_status = ST_INVALID;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = new_byte;
                    n_status  = ST_OK;
                    for (int k = 1; k < 8; k++)
                        n_runs[k] = r_runs[k] + 13'(ca[k]) - 13'(cb[k]);
                    if (r_op == OP_EXTEND) begin
                        if (ram_rdata == 8'hFF) begin
                            n_blocks = (r_blocks == 10'd0) ? 10'd0 : r_blocks - 10'd1;
                            n_frags  = r_frags + 13'd8 - 13'(r_len - r_oldc);
                        end else begin
                            n_frags = (r_frags > 13'(r_len - r_oldc))
                                      ? r_frags - 13'(r_len - r_oldc) : 13'd0;
                        end
                    end else if (new_byte == 8'hFF) begin
                        n_frags  = (sum_frags > 13'd8) ? sum_frags - 13'd8 : 13'd0;
                        n_blocks = r_blocks + 10'd1;
                    end else begin
                        n_frags = sum_frags;
                    end
                end
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                if (n_status != ST_OK) n_where = '0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_valid && o_ready) begin
            n_state  = S_READ;
            n_where  = '0;
            n_addr   = i_frag_index[11:3];
            ram_addr = i_frag_index[11:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_op         <= OP_ALLOC;
            r_data_start <= '0;
            r_blocks     <= 10'(NUM_BLOCKS);
            r_frags      <= '0;
            for (int k = 1; k < 8; k++) r_runs[k] <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_blocks <= n_blocks;
            r_frags  <= n_frags;
            r_runs   <= n_runs;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_data_start <= i_cfg_wdata;
            if (r_state == S_IDLE && i_valid && o_ready) r_op <= i_opcode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_where  <= n_where;
        if (r_state == S_IDLE && i_valid && o_ready) begin
            r_idx  <= i_frag_index;
            r_oldc <= i_old_count;
            r_len  <= i_run_length;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_alloc_index = r_where;
    assign o_free_blocks = r_blocks;
    assign o_part_frags  = r_frags;
endmodule
`default_nettype wire

>>> rtl/fba_ram.sv
// fba_ram: generic single-port RAM with registered read
// no dependencies
`default_nettype none
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/fba_checker.sv
// fba_port_checker: port-level assertions for fragment_block_allocator
// depends on fba_pkg; bound to the top level
`default_nettype none
module fba_port_checker
    import fba_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  o_status,
    input wire logic [11:0] o_alloc_index,
    input wire logic [9:0]  o_free_blocks
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_alloc_index))
        else $error("result beat changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a result waits");
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_alloc_index == 12'd0)
        else $error("failed beat carries an index");
    a_blocks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_blocks <= 10'(NUM_BLOCKS))
        else $error("free block count out of range");
endmodule

bind fragment_block_allocator fba_port_checker u_fba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_alloc_index(o_alloc_index), .o_free_blocks(o_free_blocks)
);
`default_nettype wire

>>> dv/fba_checker.sv
// fba_checker: watches the item and result channels of fragment_block_allocator,
// predicts each result from its own bitmap model and compares field by field; uses fba_pkg
`timescale 1ns / 100ps
module fba_checker
    import fba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_wdata,
    input  wire logic        i_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [11:0] i_frag_index,
    input  wire logic [3:0]  i_old_count,
    input  wire logic [3:0]  i_run_length,
    input  wire logic        i_out_valid,
    input  wire logic        i_ready,
    input  wire logic [1:0]  i_status,
    input  wire logic [11:0] i_alloc_index,
    input  wire logic [9:0]  i_free_blocks,
    input  wire logic [12:0] i_part_frags,
    output int               o_errors,
    output int               o_pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] alloc_index;
        logic [9:0]  free_blocks;
        logic [12:0] part_frags;
    } t_result;

    // shadow of the group; the run-length table never reaches the outputs
    logic [7:0]  shadow_map [NUM_BLOCKS];
    logic [9:0]  shadow_blocks;
    logic [12:0] shadow_frags;
    logic [11:0] shadow_start;
    t_result     result_q [$];

    function automatic void fresh_group();
        for (int b = 0; b < NUM_BLOCKS; b++) shadow_map[b] = 8'hff;
        shadow_blocks = 10'(NUM_BLOCKS);
        shadow_frags  = '0;
    endfunction

    function automatic logic [12:0] sub_floor(logic [12:0] a, logic [12:0] b);
        return (a > b) ? a - b : 13'd0;
    endfunction

    function automatic t_result predict_beat(logic [1:0] op, logic [11:0] idx,
                                             logic [3:0] oldc, logic [3:0] len);
        t_result r;
        int      blk, off, first;
        logic [7:0] mask;
        r = '0;
        blk = idx / BLK_FRAGS;
        off = idx % BLK_FRAGS;
        case (op)
            OP_ALLOC: begin
                if (len == 0 || len > BLK_FRAGS) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = ST_NOSPACE;
                    if (shadow_blocks != 0) begin
                        first = (int'(shadow_start) + BLK_FRAGS - 1) / BLK_FRAGS;
                        for (int b = first; b < NUM_BLOCKS; b++) begin
                            if (shadow_map[b] == 8'hff) begin
                                shadow_map[b] = 8'hff << len;
                                shadow_blocks = (shadow_blocks != 10'd0)
                                                ? shadow_blocks - 10'd1 : 10'd0;
                                shadow_frags  = shadow_frags + 13'(BLK_FRAGS - len);
                                r.status      = ST_OK;
                                r.alloc_index = 12'(b * BLK_FRAGS);
                                break;
                            end
                        end
                    end
                end
            end
            OP_EXTEND: begin
                if (len <= oldc || len > BLK_FRAGS) begin
                    r.status = ST_INVALID;
                end else if (off + len > BLK_FRAGS) begin
                    r.status = ST_NOSPACE;
                end else begin
                    mask = '0;
                    for (int i = off + oldc; i < off + len; i++) mask[i] = 1'b1;
                    if ((shadow_map[blk] & mask) != mask) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        // a fully free block turns partial: its leftovers become fragments
                        if (shadow_map[blk] == 8'hff) begin
                            shadow_blocks = (shadow_blocks != 10'd0)
                                            ? shadow_blocks - 10'd1 : 10'd0;
                            shadow_frags  = shadow_frags + 13'(BLK_FRAGS - (len - oldc));
                        end else begin
                            shadow_frags = sub_floor(shadow_frags, 13'(len - oldc));
                        end
                        shadow_map[blk] = shadow_map[blk] & ~mask;
                    end
                end
            end
            OP_FREE: begin
                mask = '0;
                for (int i = off; i < off + len && i < 8; i++) mask[i] = 1'b1;
                if (len == 0 || len > BLK_FRAGS || off + len > BLK_FRAGS
                        || (shadow_map[blk] & mask) != 0) begin
                    r.status = ST_INVALID;
                end else begin
                    shadow_map[blk] = shadow_map[blk] | mask;
                    shadow_frags    = shadow_frags + 13'(len);
                    if (shadow_map[blk] == 8'hff) begin
                        shadow_frags  = sub_floor(shadow_frags, 13'(BLK_FRAGS));
                        shadow_blocks = shadow_blocks + 10'd1;
                    end
                end
            end
            default: fresh_group();
        endcase
        r.free_blocks = shadow_blocks;
        r.part_frags  = shadow_frags;
        return r;
    endfunction

    task automatic report_mismatch(string field, int exp_v, int got_v);
        $display("mismatch %s: expected %0d got %0d at %0t", field, exp_v, got_v, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        shadow_start = '0;
        fresh_group();
    end

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            fresh_group();
            shadow_start = '0;
            result_q.delete();
        end else begin
            if (i_out_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 1);
                end else begin
                    e = result_q.pop_front();
                    if (i_status != e.status) report_mismatch("status", e.status, i_status);
                    if (i_alloc_index != e.alloc_index)
                        report_mismatch("alloc_index", e.alloc_index, i_alloc_index);
                    if (i_free_blocks != e.free_blocks)
                        report_mismatch("free_blocks", e.free_blocks, i_free_blocks);
                    if (i_part_frags != e.part_frags)
                        report_mismatch("part_frags", e.part_frags, i_part_frags);
                end
            end
            if (i_valid && i_in_ready)
                result_q.push_back(predict_beat(i_opcode, i_frag_index, i_old_count,
                                                i_run_length));
            if (i_cfg_we) shadow_start = i_cfg_wdata;
        end
        o_pending = result_q.size();
    end
endmodule

>>> dv/tb_fragment_block_allocator.sv
// tb_fragment_block_allocator: stimulus, idling and verdict for fragment_block_allocator
// depends on fba_pkg, the block itself and fba_checker
`timescale 1ns / 100ps
module tb_fragment_block_allocator;
    import fba_pkg::*;

    localparam int STALL_LIMIT = 20000;   // idle cycles before giving up
    localparam int PHASE_ITEMS = 400;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_wdata;
    logic        i_valid, o_ready;
    logic [1:0]  i_opcode;
    logic [11:0] i_frag_index;
    logic [3:0]  i_old_count, i_run_length;
    logic        o_valid, i_ready;
    logic [1:0]  o_status;
    logic [11:0] o_alloc_index;
    logic [9:0]  o_free_blocks;
    logic [12:0] o_part_frags;
    int          n_errors, n_pending;

    int          send_idle_pct, recv_idle_pct;
    int          recv_hold;          // request for a long receiver hold-off
    logic [11:0] region_start;       // where allocations land in this phase
    int          quiet_cycles;

    fragment_block_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_frag_index(i_frag_index),
        .i_old_count(i_old_count), .i_run_length(i_run_length),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_alloc_index(o_alloc_index),
        .o_free_blocks(o_free_blocks), .o_part_frags(o_part_frags)
    );

    fba_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_in_ready(o_ready),
        .i_opcode(i_opcode), .i_frag_index(i_frag_index),
        .i_old_count(i_old_count), .i_run_length(i_run_length),
        .i_out_valid(o_valid), .i_ready(i_ready),
        .i_status(o_status), .i_alloc_index(o_alloc_index),
        .i_free_blocks(o_free_blocks), .i_part_frags(o_part_frags),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls, or one long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_hold > 0) begin
                hold_left = recv_hold;
                recv_hold = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL fragment_block_allocator");
                $finish;
            end
        end
    end

    // one item beat; here valid is only dropped for a sender gap
    task automatic send_beat(logic [1:0] op, logic [11:0] idx, logic [3:0] oldc,
                             logic [3:0] len);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_frag_index <= idx;
        i_old_count  <= oldc;
        i_run_length <= len;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // block is idle once every result is back; the checker updates its count on a
    // clock edge, so step to an edge before looking
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (n_pending == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_start(logic [11:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        region_start = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly well-formed traffic aimed at the allocated region, some noise
    task automatic random_beat();
        int          pick;
        logic [11:0] idx;
        logic [3:0]  oldc, len;
        pick = $urandom_range(0, 99);
        oldc = 4'($urandom_range(0, 7));
        len  = 4'($urandom_range(1, 8));
        idx  = 12'(region_start + $urandom_range(0, 511));
        if (pick < 35) begin
            send_beat(OP_ALLOC, 12'($urandom), 4'($urandom), len);
        end else if (pick < 55) begin
            // extend a run from an aligned-ish start inside a used block
            send_beat(OP_EXTEND, {idx[11:3], 3'($urandom_range(0, 3))}, oldc,
                      4'($urandom_range(oldc + 1, 8)));
        end else if (pick < 85) begin
            send_beat(OP_FREE, idx, 4'($urandom), 4'($urandom_range(1, 8 - idx[2:0])));
        end else if (pick < 86) begin
            send_beat(OP_INIT, 12'($urandom), 4'($urandom), 4'($urandom));
        end else begin
            send_beat(2'($urandom), 12'($urandom), 4'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_valid       = 1'b0;
        i_opcode      = OP_ALLOC;
        i_frag_index  = '0;
        i_old_count   = '0;
        i_run_length  = '0;
        send_idle_pct = 11;
        recv_idle_pct = 71;
        recv_hold     = 0;
        region_start  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad lengths, extremes, each special case
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd0);        // zero length
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd15);       // length above a block
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd8);        // whole block
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd1);        // single fragment at 8
        send_beat(OP_EXTEND, 12'd8, 4'd1, 4'd1);       // new length not above old
        send_beat(OP_EXTEND, 12'd8, 4'd1, 4'd9);       // new length above a block
        send_beat(OP_EXTEND, 12'd14, 4'd1, 4'd3);      // past block end
        send_beat(OP_EXTEND, 12'd8, 4'd1, 4'd5);       // normal grow
        send_beat(OP_EXTEND, 12'd8, 4'd0, 4'd2);       // added fragment already used
        send_beat(OP_EXTEND, 12'd4088, 4'd0, 4'd3);    // from a fully free block, top end
        send_beat(OP_FREE, 12'd9, 4'd0, 4'd2);         // partial free
        send_beat(OP_FREE, 12'd9, 4'd0, 4'd2);         // already free
        send_beat(OP_FREE, 12'd15, 4'd0, 4'd2);        // past block end
        send_beat(OP_FREE, 12'd0, 4'd0, 4'd0);         // zero length
        send_beat(OP_FREE, 12'd0, 4'd15, 4'd15);       // too long
        send_beat(OP_FREE, 12'd8, 4'd0, 4'd1);
        send_beat(OP_FREE, 12'd11, 4'd0, 4'd5);        // reaches already free fragments, rejected
        send_beat(OP_FREE, 12'd0, 4'd0, 4'd8);         // whole block back
        send_beat(OP_FREE, 12'd4095, 4'd0, 4'd1);      // top fragment, already free
        send_beat(OP_INIT, 12'hfff, 4'hf, 4'hf);
        write_start(12'd4095);                         // nothing past the rounded start
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd3);
        write_start(12'd4089);                         // also rounds up past the last block
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd7);
        send_beat(OP_ALLOC, 12'd0, 4'd0, 4'd7);        // no block left past start

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_start(12'd0);
                1: write_start(12'd3900);
                2: write_start(12'd1234);
                3: write_start(12'd4095);
                default: write_start(12'd0);
            endcase
            if (phase >= 2 && phase < 4) begin
                send_idle_pct = 71;
                recv_idle_pct = 11;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 2) recv_hold = 400;   // fills the block, input must stall
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == PHASE_ITEMS / 2) drain();
                random_beat();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS fragment_block_allocator");
        end else begin
            $display("FAIL fragment_block_allocator");
        end
        $finish;
    end
endmodule
